// ===== hw/rtl/etp_pkg.sv =====
`default_nettype none
package etp_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int NORM_BITS = 30;
	// CORDIC datapath width: magnitudes stay below 2^33 in both rotations
	localparam int CW = 35;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

	localparam int DEF_MAX_OUTPUT_SIDE = 4096;
	localparam int DEF_MAX_SOURCE_SIDE = 8192;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 54;

	localparam logic [CFG_AW-1:0] REG_INV_FOCAL  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_CX_OFFSET  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_CY_OFFSET  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_ROT_ROW0   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_ROT_ROW1   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_ROT_ROW2   = 3'd5;
	localparam logic [CFG_AW-1:0] REG_SRC_WM1    = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SRC_HM1    = 3'd7;

	typedef struct packed {
		logic signed [CW-1:0] re;
		logic signed [CW-1:0] im;
		logic signed [CW-1:0] ang;
	} etp_cvec_t;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage
`default_nettype wire

// ===== hw/rtl/equirect_to_perspective_coord_map.sv =====
`default_nettype none
// Maps each perspective-view pixel (pixel_col, pixel_row) to the Q13.8
// sample position (src_x, src_y) in an equirectangular source image. The
// ray is rotated by the configured 3x3 matrix, normalized, and turned into
// longitude and latitude by two 30-step CORDIC vectoring chains, one
// register stage per step. Throughput is one transaction per clock while
// coord_ready holds; the pipeline is 72 register stages deep. The depth
// is set by the two CORDIC chains plus ray, matrix, normalize, gain and
// scaling stages. Each stage holds its own valid bit, so bubbles are
// squeezed out and a stalled output only blocks input once every stage is
// full. Configuration is written through cfg_we/cfg_addr/cfg_wdata and
// must change only while the pipeline is empty.
module equirect_to_perspective_coord_map #(
	parameter int MAX_OUTPUT_SIDE = etp_pkg::DEF_MAX_OUTPUT_SIDE,
	parameter int MAX_SOURCE_SIDE = etp_pkg::DEF_MAX_SOURCE_SIDE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [etp_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [etp_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  logic [11:0]                pixel_col,
	input  logic [11:0]                pixel_row,
	output logic                       coord_valid,
	input  logic                       coord_ready,
	output logic [20:0]                src_x,
	output logic [20:0]                src_y
);
	import etp_pkg::*;

	// stage map
	localparam int ST_RAY  = 0;
	localparam int ST_PROD = 1;
	localparam int ST_SUM  = 2;
	localparam int ST_MAX  = 3;
	localparam int ST_LEN  = 4;
	localparam int ST_NORM = 5;
	localparam int ST_PRE  = 6;
	localparam int ST_LON0 = 7;
	localparam int ST_GMUL = ST_LON0 + CORDIC_STEPS;
	localparam int ST_GRND = ST_GMUL + 1;
	localparam int ST_LAT0 = ST_GRND + 1;
	localparam int ST_FRAC = ST_LAT0 + CORDIC_STEPS;
	localparam int ST_OMUL = ST_FRAC + 1;
	localparam int ST_OUT  = ST_OMUL + 1;
	localparam int NST     = ST_OUT + 1;

	// saturation limits; a limit beyond the field width never bites
	localparam logic [11:0] COL_MAX =
		(MAX_OUTPUT_SIDE - 1 > 4095) ? 12'hFFF : 12'(MAX_OUTPUT_SIDE - 1);
	localparam logic [12:0] SIDE_MAX =
		(MAX_SOURCE_SIDE - 1 > 8191) ? 13'h1FFF : 13'(MAX_SOURCE_SIDE - 1);

	localparam int LON_PW = 33;   // {zero flag, y component}
	localparam int LAT_PW = CW + 1; // {zero flag, longitude}

	// ---------------- configuration registers ----------------
	logic [23:0]        inv_focal_q;
	logic signed [24:0] cx_off_q;
	logic signed [24:0] cy_off_q;
	logic [53:0]        rot_q [3];
	logic [12:0]        w1_q;
	logic [12:0]        h1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_q <= 24'd32768;
			cx_off_q    <= -25'sd1047552;
			cy_off_q    <= -25'sd1047552;
			rot_q[0]    <= 54'd65536;
			rot_q[1]    <= 54'd17179869184;
			rot_q[2]    <= 54'd4503599627370496;
			w1_q        <= 13'd4095;
			h1_q        <= 13'd2047;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_INV_FOCAL: inv_focal_q <= cfg_wdata[23:0];
				REG_CX_OFFSET: cx_off_q    <= $signed(cfg_wdata[24:0]);
				REG_CY_OFFSET: cy_off_q    <= $signed(cfg_wdata[24:0]);
				REG_ROT_ROW0:  rot_q[0]    <= cfg_wdata[53:0];
				REG_ROT_ROW1:  rot_q[1]    <= cfg_wdata[53:0];
				REG_ROT_ROW2:  rot_q[2]    <= cfg_wdata[53:0];
				REG_SRC_WM1:   w1_q        <= cfg_wdata[12:0];
				REG_SRC_HM1:   h1_q        <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	logic [12:0] w1_sat;
	logic [12:0] h1_sat;
	assign w1_sat = (w1_q > SIDE_MAX) ? SIDE_MAX : w1_q;
	assign h1_sat = (h1_q > SIDE_MAX) ? SIDE_MAX : h1_q;

	// ---------------- pipeline control ----------------
	// A stage loads when it is empty or its successor loads.
	logic [NST-1:0] vld_q;
	logic [NST:0]   ld;

	always_comb begin
		ld[NST] = coord_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) vld_q[0] <= pix_valid;
			for (int k = 1; k < NST; k++) begin
				if (ld[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pix_ready   = ld[0];
	assign coord_valid = vld_q[NST-1];

	// ---------------- stage 1: ray ----------------
	logic [11:0]        col_sat;
	logic [11:0]        row_sat;
	logic [35:0]        col_prod;
	logic [35:0]        row_prod;
	logic signed [37:0] ray_x_s1;
	logic signed [37:0] ray_y_s1;

	assign col_sat  = (pixel_col > COL_MAX) ? COL_MAX : pixel_col;
	assign row_sat  = (pixel_row > COL_MAX) ? COL_MAX : pixel_row;
	assign col_prod = {24'b0, col_sat} * {12'b0, inv_focal_q};
	assign row_prod = {24'b0, row_sat} * {12'b0, inv_focal_q};

	always_ff @(posedge clk) begin
		if (ld[ST_RAY]) begin
			ray_x_s1 <= $signed({2'b00, col_prod}) + $signed({{9{cx_off_q[24]}}, cx_off_q, 4'b0});
			ray_y_s1 <= $signed({2'b00, row_prod}) + $signed({{9{cy_off_q[24]}}, cy_off_q, 4'b0});
		end
	end

	// ---------------- stage 2: matrix products ----------------
	logic signed [55:0] px_s2 [3];
	logic signed [55:0] py_s2 [3];

	always_ff @(posedge clk) begin
		if (ld[ST_PROD]) begin
			for (int k = 0; k < 3; k++) begin
				px_s2[k] <= ray_x_s1 * $signed(rot_q[k][17:0]);
				py_s2[k] <= ray_y_s1 * $signed(rot_q[k][35:18]);
			end
		end
	end

	// ---------------- stage 3: row sums (z term is entry times 2^24) ------
	logic signed [59:0] sum_s3 [3];

	always_ff @(posedge clk) begin
		if (ld[ST_SUM]) begin
			for (int k = 0; k < 3; k++) begin
				sum_s3[k] <= $signed({{4{px_s2[k][55]}}, px_s2[k]})
					+ $signed({{4{py_s2[k][55]}}, py_s2[k]})
					+ $signed({{18{rot_q[k][53]}}, rot_q[k][53:36], 24'b0});
			end
		end
	end

	// ---------------- stage 4: largest magnitude ----------------
	logic [59:0]        absv [3];
	logic [59:0]        mx_c;
	logic [59:0]        mx_s4;
	logic signed [59:0] vec_s4 [3];

	always_comb begin
		mx_c = '0;
		for (int k = 0; k < 3; k++) begin
			absv[k] = sum_s3[k][59] ? 60'(-sum_s3[k]) : 60'(sum_s3[k]);
			if (absv[k] > mx_c) mx_c = absv[k];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[ST_MAX]) begin
			mx_s4  <= mx_c;
			vec_s4 <= sum_s3;
		end
	end

	// ---------------- stage 5: bit length ----------------
	logic [6:0]         len_c;
	logic [6:0]         len_s5;
	logic signed [59:0] vec_s5 [3];

	always_comb begin
		len_c = '0;
		for (int b = 0; b < 60; b++) begin
			if (mx_s4[b]) len_c = 7'(b + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[ST_LEN]) begin
			len_s5 <= len_c;
			vec_s5 <= vec_s4;
		end
	end

	// ---------------- stage 6: normalize to [2^29, 2^30) ----------------
	logic signed [59:0] nrm_c [3];
	logic signed [31:0] nrm_s6 [3];
	logic               zero_s6;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (len_s5 > 7'(NORM_BITS)) begin
				nrm_c[k] = vec_s5[k] >>> (len_s5 - 7'(NORM_BITS));
			end else begin
				nrm_c[k] = vec_s5[k] <<< (7'(NORM_BITS) - len_s5);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[ST_NORM]) begin
			for (int k = 0; k < 3; k++) begin
				nrm_s6[k] <= nrm_c[k][31:0];
			end
			zero_s6 <= (len_s5 == 7'd0);
		end
	end

	// ---------------- stage 7: quarter-turn pre-rotation ----------------
	etp_cvec_t          pre_c;
	etp_cvec_t          pre_s7;
	logic [LON_PW-1:0]  pre_side_s7;
	logic signed [CW-1:0] zx;
	logic signed [CW-1:0] xx;

	assign zx = CW'(nrm_s6[2]);
	assign xx = CW'(nrm_s6[0]);

	always_comb begin
		pre_c.re  = zx;
		pre_c.im  = xx;
		pre_c.ang = '0;
		if (zx < 0) begin
			if (xx >= 0) begin
				pre_c.re  = xx;
				pre_c.im  = -zx;
				pre_c.ang = CW'(64'sd1 <<< 30);
			end else begin
				pre_c.re  = -xx;
				pre_c.im  = zx;
				pre_c.ang = -CW'(64'sd1 <<< 30);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[ST_PRE]) begin
			pre_s7      <= pre_c;
			pre_side_s7 <= {zero_s6, nrm_s6[1]};
		end
	end

	// ---------------- longitude CORDIC ----------------
	etp_cvec_t         lon_vec  [CORDIC_STEPS+1];
	logic [LON_PW-1:0] lon_side [CORDIC_STEPS+1];

	assign lon_vec[0]  = pre_s7;
	assign lon_side[0] = pre_side_s7;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_lon
		etp_cordic_step #(.SHIFT(i), .PW(LON_PW)) u_step (
			.clk      (clk),
			.ld       (ld[ST_LON0+i]),
			.vec_in   (lon_vec[i]),
			.side_in  (lon_side[i]),
			.vec_out  (lon_vec[i+1]),
			.side_out (lon_side[i+1])
		);
	end

	// ---------------- gain correction ----------------
	logic [63:0]          gprod_s38;
	logic signed [CW-1:0] glon_s38;
	logic [LON_PW-1:0]    gside_s38;

	always_ff @(posedge clk) begin
		if (ld[ST_GMUL]) begin
			gprod_s38 <= {30'b0, lon_vec[CORDIC_STEPS].re[33:0]} * {34'b0, INV_GAIN_Q30};
			glon_s38  <= lon_vec[CORDIC_STEPS].ang;
			gside_s38 <= lon_side[CORDIC_STEPS];
		end
	end

	logic [63:0]       grnd_c;
	etp_cvec_t         lat_in_s39;
	logic [LAT_PW-1:0] lat_side_s39;

	assign grnd_c = gprod_s38 + 64'(1 << 29);

	always_ff @(posedge clk) begin
		if (ld[ST_GRND]) begin
			lat_in_s39.re  <= $signed({1'b0, grnd_c[63:30]});
			lat_in_s39.im  <= CW'($signed(gside_s38[31:0]));
			lat_in_s39.ang <= '0;
			lat_side_s39   <= {gside_s38[32], glon_s38};
		end
	end

	// ---------------- latitude CORDIC ----------------
	etp_cvec_t         lat_vec  [CORDIC_STEPS+1];
	logic [LAT_PW-1:0] lat_side [CORDIC_STEPS+1];

	assign lat_vec[0]  = lat_in_s39;
	assign lat_side[0] = lat_side_s39;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_lat
		etp_cordic_step #(.SHIFT(i), .PW(LAT_PW)) u_step (
			.clk      (clk),
			.ld       (ld[ST_LAT0+i]),
			.vec_in   (lat_vec[i]),
			.side_in  (lat_side[i]),
			.vec_out  (lat_vec[i+1]),
			.side_out (lat_side[i+1])
		);
	end

	// ---------------- fractions of a turn, clamped to [0, 2^32] ------------
	logic signed [CW+1:0] fu_c;
	logic signed [CW+1:0] fv_c;
	logic [32:0]          fu_s70;
	logic [32:0]          fv_s70;
	logic                 zero_lat;

	localparam logic signed [CW+1:0] HALF = (CW+2)'(64'sd1 <<< 31);
	localparam logic signed [CW+1:0] ONE  = (CW+2)'(64'sd1 <<< 32);

	assign zero_lat = lat_side[CORDIC_STEPS][CW];
	assign fu_c = (CW+2)'($signed(lat_side[CORDIC_STEPS][CW-1:0])) + HALF;
	assign fv_c = ((CW+2)'($signed(lat_vec[CORDIC_STEPS].ang)) <<< 1) + HALF;

	always_ff @(posedge clk) begin
		if (ld[ST_FRAC]) begin
			if (zero_lat) begin
				// degenerate ray: aim at the source center
				fu_s70 <= 33'(HALF);
				fv_s70 <= 33'(HALF);
			end else begin
				fu_s70 <= (fu_c < 0) ? 33'd0 : (fu_c > ONE) ? 33'(ONE) : fu_c[32:0];
				fv_s70 <= (fv_c < 0) ? 33'd0 : (fv_c > ONE) ? 33'(ONE) : fv_c[32:0];
			end
		end
	end

	// ---------------- scale by source size ----------------
	logic [45:0] ox_s71;
	logic [45:0] oy_s71;

	always_ff @(posedge clk) begin
		if (ld[ST_OMUL]) begin
			ox_s71 <= {13'b0, fu_s70} * {33'b0, w1_sat};
			oy_s71 <= {13'b0, fv_s70} * {33'b0, h1_sat};
		end
	end

	// ---------------- round half up to Q13.8 ----------------
	logic [45:0] rx_c;
	logic [45:0] ry_c;
	logic [20:0] src_x_s72;
	logic [20:0] src_y_s72;

	assign rx_c = ox_s71 + 46'(1 << 23);
	assign ry_c = oy_s71 + 46'(1 << 23);

	always_ff @(posedge clk) begin
		if (ld[ST_OUT]) begin
			src_x_s72 <= rx_c[44:24];
			src_y_s72 <= ry_c[44:24];
		end
	end

	assign src_x = src_x_s72;
	assign src_y = src_y_s72;

	// ---------------- assertions ----------------
	a_in_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> vld_q[ST_RAY])
		else $error("accepted pixel did not enter first stage");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !coord_ready |-> !pix_ready)
		else $error("full stalled pipeline accepted a pixel");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid |-> src_x <= {w1_sat, 8'b0})
		else $error("src_x beyond source width");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid |-> src_y <= {h1_sat, 8'b0})
		else $error("src_y beyond source height");

endmodule
`default_nettype wire

// ===== hw/rtl/etp_cordic_step.sv =====
`default_nettype none
module etp_cordic_step #(
	parameter int SHIFT = 0,
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                ld,
	input  etp_pkg::etp_cvec_t  vec_in,
	input  logic [PW-1:0]       side_in,
	output etp_pkg::etp_cvec_t  vec_out,
	output logic [PW-1:0]       side_out
);
	import etp_pkg::*;

	logic signed [CW-1:0] dr;
	logic signed [CW-1:0] di;
	logic signed [CW-1:0] atan_ext;
	etp_cvec_t            nxt;

	// floor shift of a signed value is an arithmetic shift
	assign dr = $signed(vec_in.im) >>> SHIFT;
	assign di = $signed(vec_in.re) >>> SHIFT;
	assign atan_ext = $signed({{(CW-32){1'b0}}, ATAN_TURNS[SHIFT]});

	always_comb begin
		if (!vec_in.im[CW-1]) begin
			nxt.re  = vec_in.re + dr;
			nxt.im  = vec_in.im - di;
			nxt.ang = vec_in.ang + atan_ext;
		end else begin
			nxt.re  = vec_in.re - dr;
			nxt.im  = vec_in.im + di;
			nxt.ang = vec_in.ang - atan_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			vec_out  <= nxt;
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire
